// ----- sv/tstc_pkg.sv -----
// Package for the time series turnover classifier: constants, types and codes.
`default_nettype none
package tstc_pkg;
  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned SampleW = 32;
  localparam int unsigned FracW = 17;
  localparam int unsigned CutW = 7;
  localparam int unsigned PosW = 6;
  localparam int unsigned OutDataW = 184;
  localparam logic [FracW-1:0] FracOne = 17'h10000;
  localparam logic [CutW-1:0] CutoffReset = 7'd1;

  localparam logic CfgChangeFraction = 1'b0;
  localparam logic CfgCountCutoff = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN1,
    ST_MUL,
    ST_SCAN2,
    ST_DONE
  } state_e;

  function automatic logic [SampleW-1:0] abs_diff(input logic signed [SampleW-1:0] a,
                                                  input logic signed [SampleW-1:0] b);
    logic signed [SampleW:0] d;
    d = {a[SampleW-1], a} - {b[SampleW-1], b};
    abs_diff = d[SampleW] ? SampleW'(-d) : d[SampleW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- sv/tstc_cell.sv -----
// One storage cell of the sample ring: holds a sample and passes it on when enabled.
`default_nettype none
module tstc_cell (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [tstc_pkg::SampleW-1:0]   d_i,
  output logic      [tstc_pkg::SampleW-1:0]   q_o
);
  logic [tstc_pkg::SampleW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;
endmodule
`default_nettype wire

// ----- sv/time_series_turnover_classifier_unit.sv -----
// Top level of the time series turnover classifier: sample ring, scan passes, result register.
//
// Samples arrive on the slave stream (tdata = sample, tlast = end of series),
// one transfer per cycle while loading. Each stored sample enters a ring of
// MAX_POINTS cells; a sample arriving with the ring full is dropped and
// reported through the overflowed bit. After the tlast transfer, the block
// rotates the ring twice, a full turn per pass: the first pass finds the
// extremes and the largest step, the MUL state forms the threshold product,
// and the second pass counts trail and lead points. No input is taken during
// the passes. The result waits in an output register until the master side
// takes it; the next series loads meanwhile and its result holds until the
// register is free. Reset empties the ring count, sets the configuration to
// its reset values and drops any pending result.
`default_nettype none
module time_series_turnover_classifier_unit #(
  parameter int unsigned MAX_POINTS = tstc_pkg::MaxPointsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [tstc_pkg::FracW-1:0]        cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample[31:0]
  input  wire logic [tstc_pkg::SampleW-1:0]      s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // min_value, max_value, min_position, max_position, start_end_diff, spread,
  // max_step, forward, pattern_flags, overflowed, zero fill
  output logic [tstc_pkg::OutDataW-1:0]          m_axis_tdata
);
  localparam int unsigned SW = tstc_pkg::SampleW;
  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned LW = SW + tstc_pkg::FracW;

  tstc_pkg::state_e state_q, state_d;

  logic [tstc_pkg::FracW-1:0] frac_q;
  logic [tstc_pkg::CutW-1:0]  cut_q;
  logic [CW-1:0]              count_q;
  logic                       drop_q;
  logic [IW-1:0]              t_q;
  logic [CW-1:0]              off_q;
  logic signed [SW-1:0]       first_q, last_q, prev_q, min_q, max_q;
  logic [IW-1:0]              min_idx_q, max_idx_q;
  logic [SW-1:0]              step_q;
  logic [LW-1:0]              limit_q;
  logic [CW-1:0]              min_trail_q, max_trail_q, min_lead_q, max_lead_q;
  logic                       out_valid_q;
  logic [tstc_pkg::OutDataW-1:0] out_data_q;

  logic [SW-1:0] cell_d [MAX_POINTS];
  logic [SW-1:0] cell_q [MAX_POINTS];
  logic          ring_en;
  logic          in_xfer, store;

  assign s_axis_tready = (state_q == tstc_pkg::ST_LOAD);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign store = in_xfer && (count_q < CW'(MAX_POINTS));
  assign ring_en = store || (state_q == tstc_pkg::ST_SCAN1) || (state_q == tstc_pkg::ST_SCAN2);

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_ring
    if (g == 0) begin : g_head
      assign cell_d[g] = (state_q == tstc_pkg::ST_LOAD) ? s_axis_tdata : cell_q[MAX_POINTS-1];
    end else begin : g_body
      assign cell_d[g] = cell_q[g-1];
    end
    tstc_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ring_en),
      .d_i   (cell_d[g]),
      .q_o   (cell_q[g])
    );
  end

  logic signed [SW-1:0] cur;
  logic                 cur_ok;
  logic [IW-1:0]        k;
  logic [CW:0]          t_ext;
  logic                 t_end;
  logic [LW-1:0]        near_max_lhs, near_min_lhs;
  logic                 near_max, near_min;
  logic [SW-1:0]        cur_step;
  logic [SW-1:0]        spread;
  logic [tstc_pkg::FracW-1:0] frac_sat;
  logic                 fwd, rev;
  logic                 min_t_hit, max_t_hit;
  logic [5:0]           flags;

  assign cur = cell_q[MAX_POINTS-1];
  assign t_ext = {1'b0, CW'(t_q)};
  assign cur_ok = t_ext >= {1'b0, off_q};
  assign k = IW'(t_ext - {1'b0, off_q});
  assign t_end = (t_q == IW'(MAX_POINTS - 1));
  assign cur_step = tstc_pkg::abs_diff(cur, prev_q);
  assign spread = SW'(max_q - min_q);
  assign frac_sat = (frac_q > tstc_pkg::FracOne) ? tstc_pkg::FracOne : frac_q;
  assign near_max_lhs = LW'({SW'(cur - min_q), 16'h0000});
  assign near_min_lhs = LW'({SW'(max_q - cur), 16'h0000});
  assign near_max = near_max_lhs >= limit_q;
  assign near_min = near_min_lhs >= limit_q;
  assign fwd = min_idx_q < max_idx_q;
  assign rev = min_idx_q > max_idx_q;
  assign min_t_hit = CW'(min_trail_q) > CW'(0) &&
                     {{(CW+tstc_pkg::CutW){1'b0}}, min_trail_q} >
                     {{(CW+tstc_pkg::CutW){1'b0}}, cut_q};
  assign max_t_hit = {{(CW+tstc_pkg::CutW){1'b0}}, max_trail_q} >
                     {{(CW+tstc_pkg::CutW){1'b0}}, cut_q};
  assign flags[0] = min_t_hit && fwd;
  assign flags[1] = min_t_hit && rev;
  assign flags[2] = {{(CW+tstc_pkg::CutW){1'b0}}, max_lead_q} >
                    {{(CW+tstc_pkg::CutW){1'b0}}, cut_q};
  assign flags[3] = max_t_hit && fwd;
  assign flags[4] = max_t_hit && rev;
  assign flags[5] = {{(CW+tstc_pkg::CutW){1'b0}}, min_lead_q} >
                    {{(CW+tstc_pkg::CutW){1'b0}}, cut_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      tstc_pkg::ST_LOAD:  if (in_xfer && s_axis_tlast) state_d = tstc_pkg::ST_SCAN1;
      tstc_pkg::ST_SCAN1: if (t_end) state_d = tstc_pkg::ST_MUL;
      tstc_pkg::ST_MUL:   state_d = tstc_pkg::ST_SCAN2;
      tstc_pkg::ST_SCAN2: if (t_end) state_d = tstc_pkg::ST_DONE;
      tstc_pkg::ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = tstc_pkg::ST_LOAD;
      default:            state_d = tstc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tstc_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
      cut_q <= tstc_pkg::CutoffReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tstc_pkg::CfgChangeFraction: frac_q <= cfg_data_i;
        tstc_pkg::CfgCountCutoff:    cut_q <= cfg_data_i[tstc_pkg::CutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q <= 1'b0;
      t_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == tstc_pkg::ST_DONE) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        tstc_pkg::ST_LOAD: begin
          if (store) count_q <= count_q + CW'(1);
          else if (in_xfer) drop_q <= 1'b1;
          t_q <= '0;
        end
        tstc_pkg::ST_SCAN1, tstc_pkg::ST_SCAN2: t_q <= t_end ? '0 : t_q + IW'(1);
        tstc_pkg::ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            count_q <= '0;
            drop_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tstc_pkg::ST_LOAD: begin
        if (store) begin
          if (count_q == '0) first_q <= s_axis_tdata;
          last_q <= s_axis_tdata;
        end
        if (in_xfer && s_axis_tlast) begin
          off_q <= CW'(MAX_POINTS) - (store ? count_q + CW'(1) : count_q);
          min_q <= store && (count_q == '0) ? s_axis_tdata : first_q;
          max_q <= store ? s_axis_tdata : last_q;
          max_idx_q <= store ? IW'(count_q) : IW'(count_q - CW'(1));
          min_idx_q <= '0;
          step_q <= '0;
        end
      end
      tstc_pkg::ST_SCAN1: begin
        if (cur_ok) begin
          if (cur > max_q) begin
            max_q <= cur;
            max_idx_q <= k;
          end
          if (cur < min_q) begin
            min_q <= cur;
            min_idx_q <= k;
          end
          if (k != '0 && cur_step > step_q) step_q <= cur_step;
        end
        prev_q <= cur;
      end
      tstc_pkg::ST_MUL: begin
        limit_q <= spread * (tstc_pkg::FracOne - frac_sat);
        min_trail_q <= '0;
        max_trail_q <= '0;
        min_lead_q <= '0;
        max_lead_q <= '0;
      end
      tstc_pkg::ST_SCAN2: begin
        if (cur_ok) begin
          if (k < min_idx_q && near_max) min_trail_q <= min_trail_q + CW'(1);
          if (k < max_idx_q && near_min) max_trail_q <= max_trail_q + CW'(1);
          if (rev && k > min_idx_q && near_max) min_lead_q <= min_lead_q + CW'(1);
          if (fwd && k > max_idx_q && near_min) max_lead_q <= max_lead_q + CW'(1);
        end
      end
      tstc_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {4'b0000, drop_q, flags, fwd, step_q, spread,
                         tstc_pkg::abs_diff(last_q, first_q),
                         tstc_pkg::PosW'(max_idx_q), tstc_pkg::PosW'(min_idx_q),
                         max_q, min_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tstc_pkg::ST_LOAD) |-> !s_axis_tready)
    else $error("input taken outside load");
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[63:32])))
    else $error("minimum above maximum");
  a_fwd_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[173] && m_axis_tdata[174]))
    else $error("min trail both directions");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("ring count beyond capacity");
`endif
endmodule
`default_nettype wire

// ----- verif/time_series_turnover_classifier_unit_tb.sv -----
// Testbench for the time series turnover classifier: directed and random series checked by a predictor.
`timescale 1ns / 100ps
module time_series_turnover_classifier_unit_tb;

  localparam int unsigned NPts = tstc_pkg::MaxPointsDefault;

  typedef struct packed {
    logic [3:0]  zfill;
    logic        overflowed;
    logic [5:0]  pattern_flags;
    logic        forward;
    logic [31:0] max_step;
    logic [31:0] spread;
    logic [31:0] start_end_diff;
    logic [5:0]  max_position;
    logic [5:0]  min_position;
    logic [31:0] max_value;
    logic [31:0] min_value;
  } summary_t;

  typedef struct {
    logic [31:0] sample;
    logic        last;
    logic        has_exp;
    summary_t    exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = tstc_pkg::CfgChangeFraction;
  logic [tstc_pkg::FracW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tstc_pkg::SampleW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tstc_pkg::OutDataW-1:0] m_axis_tdata;

  time_series_turnover_classifier_unit uut (.*);

  always #5 clk_i = ~clk_i;

  logic signed [31:0] series_buf[NPts];
  int unsigned series_len;
  logic series_dropped;
  logic [16:0] frac_reg;
  logic [6:0] cutoff_reg;
  summary_t summary_q[$];
  row_t dir_rows[$];
  int errors = 0;
  int cycles = 0;
  bit rx_hold = 0;
  bit stim_done = 0;

  function automatic summary_t classify_series();
    summary_t r;
    int unsigned n, mi, xi;
    longint signed mn, mx, s;
    longint unsigned spr, lim, stp, dl, d;
    int unsigned mtr, xtr, mld, xld;
    bit nmax, nmin, fwd, rev;
    n = series_len;
    mn = series_buf[0]; mi = 0;
    mx = series_buf[n-1]; xi = n - 1;
    stp = 0;
    for (int i = 0; i < n; i++) begin
      s = series_buf[i];
      if (s > mx) begin mx = s; xi = i; end
      if (s < mn) begin mn = s; mi = i; end
      if (i > 0) begin
        dl = (s > series_buf[i-1]) ? s - series_buf[i-1] : series_buf[i-1] - s;
        if (dl > stp) stp = dl;
      end
    end
    spr = mx - mn;
    d = (frac_reg > 17'h10000) ? 64'h10000 : frac_reg;
    lim = spr * (64'h10000 - d);
    mtr = 0; xtr = 0; mld = 0; xld = 0;
    for (int i = 0; i < n; i++) begin
      s = series_buf[i];
      nmax = ((s - mn) * 65536) >= lim;
      nmin = ((mx - s) * 65536) >= lim;
      if (i < mi && nmax) mtr++;
      if (i < xi && nmin) xtr++;
      if (xi < mi && i > mi && nmax) mld++;
      if (mi < xi && i > xi && nmin) xld++;
    end
    fwd = mi < xi;
    rev = mi > xi;
    r = '0;
    r.min_value = mn[31:0];
    r.max_value = mx[31:0];
    r.min_position = mi[5:0];
    r.max_position = xi[5:0];
    s = series_buf[n-1] - series_buf[0];
    r.start_end_diff = (s < 0) ? 32'(-s) : 32'(s);
    r.spread = spr[31:0];
    r.max_step = stp[31:0];
    r.forward = fwd;
    r.pattern_flags[0] = mtr > cutoff_reg && fwd;
    r.pattern_flags[1] = mtr > cutoff_reg && rev;
    r.pattern_flags[2] = xld > cutoff_reg;
    r.pattern_flags[3] = xtr > cutoff_reg && fwd;
    r.pattern_flags[4] = xtr > cutoff_reg && rev;
    r.pattern_flags[5] = mld > cutoff_reg;
    r.overflowed = series_dropped;
    return r;
  endfunction

  // accept one sample into the model; return 1 when a summary is due
  function automatic bit model_accept(logic [31:0] smp, logic lst);
    if (series_len < NPts) begin
      series_buf[series_len] = smp;
      series_len++;
    end else begin
      series_dropped = 1'b1;
    end
    return lst;
  endfunction

  task automatic send_sample(logic [31:0] smp, logic lst, bit has_exp, summary_t exp);
    summary_t p;
    int unsigned w;
    w = $urandom_range(0, 4);
    if (w != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    if (model_accept(smp, lst)) begin
      p = classify_series();
      if (has_exp && p != exp) begin
        $error("directed row mismatch: table %h predictor %h", exp, p);
        errors++;
      end
      summary_q = {summary_q, p};
      series_len = 0;
      series_dropped = 1'b0;
    end
  endtask

  task automatic write_reg(logic idx, logic [tstc_pkg::FracW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (2 * NPts + 8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tstc_pkg::CfgChangeFraction) frac_reg = val;
    else cutoff_reg = val[6:0];
  endtask

  task automatic send_series(int unsigned len, int mode);
    logic [31:0] v;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = $urandom_range(0, 40) - 20;
        2: v = (i * 37 + $urandom_range(0, 3)) << $urandom_range(0, 12);
        default: v = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                          : 32'h80000000 + $urandom_range(0, 3);
      endcase
      send_sample(v, i == len - 1, 1'b0, '0);
    end
  endtask

  function automatic row_t mk(logic [31:0] s, logic l);
    row_t r;
    r.sample = s; r.last = l; r.has_exp = 1'b0; r.exp = '0;
    return r;
  endfunction

  function automatic summary_t exp_single(logic [31:0] v, logic ovf);
    summary_t e;
    e = '0;
    e.min_value = v; e.max_value = v; e.overflowed = ovf;
    return e;
  endfunction

  initial begin
    row_t r;
    frac_reg = '0;
    cutoff_reg = tstc_pkg::CutoffReset;
    series_len = 0;
    series_dropped = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample series at the extremes and at zero, known summaries
    r = mk(32'h7fffffff, 1'b1); r.has_exp = 1; r.exp = exp_single(32'h7fffffff, 0);
    dir_rows = {dir_rows, r};
    r = mk(32'h80000000, 1'b1); r.has_exp = 1; r.exp = exp_single(32'h80000000, 0);
    dir_rows = {dir_rows, r};
    r = mk(32'h0, 1'b1); r.has_exp = 1; r.exp = exp_single(32'h0, 0);
    dir_rows = {dir_rows, r};
    // full-scale swing, min first
    dir_rows = {dir_rows, mk(32'h80000000, 1'b0)};
    r = mk(32'h7fffffff, 1'b1); r.has_exp = 1; r.exp = '0;
    r.exp.min_value = 32'h80000000; r.exp.max_value = 32'h7fffffff;
    r.exp.max_position = 6'd1; r.exp.start_end_diff = 32'hffffffff;
    r.exp.spread = 32'hffffffff; r.exp.max_step = 32'hffffffff; r.exp.forward = 1'b1;
    dir_rows = {dir_rows, r};
    // ties: max chosen at last point, min at first
    dir_rows = {dir_rows, mk(32'd5, 1'b0)};
    dir_rows = {dir_rows, mk(32'd5, 1'b0)};
    dir_rows = {dir_rows, mk(32'd5, 1'b1)};
    // reverse: maximum before minimum, then a rising tail
    dir_rows = {dir_rows, mk(32'd100, 1'b0)};
    dir_rows = {dir_rows, mk(32'd90, 1'b0)};
    dir_rows = {dir_rows, mk(32'd200, 1'b0)};
    dir_rows = {dir_rows, mk(32'd0, 1'b0)};
    dir_rows = {dir_rows, mk(32'd1, 1'b0)};
    dir_rows = {dir_rows, mk(32'd2, 1'b0)};
    dir_rows = {dir_rows, mk(32'd3, 1'b1)};
    foreach (dir_rows[i])
      send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].has_exp, dir_rows[i].exp);

    // overflow: 66 samples, the last two dropped; the last still closes the series
    for (int i = 0; i < NPts + 2; i++)
      send_sample(i == 7 ? 32'hffff0000 : i * 3, i == NPts + 1, 1'b0, '0);

    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tstc_pkg::CfgChangeFraction, 17'h10000);
          write_reg(tstc_pkg::CfgCountCutoff, 17'd0);
        end
        1: begin
          write_reg(tstc_pkg::CfgChangeFraction, 17'h1ffff);
          write_reg(tstc_pkg::CfgCountCutoff, 17'd64);
        end
        2: begin
          write_reg(tstc_pkg::CfgChangeFraction, 17'd0);
          write_reg(tstc_pkg::CfgCountCutoff, 17'd0);
        end
        3: begin
          write_reg(tstc_pkg::CfgChangeFraction, 17'h08000);
          write_reg(tstc_pkg::CfgCountCutoff, 17'd1);
        end
        4: begin
          write_reg(tstc_pkg::CfgChangeFraction, 17'h0ccc);
          write_reg(tstc_pkg::CfgCountCutoff, 17'd127);
        end
        default: begin
          write_reg(tstc_pkg::CfgChangeFraction,
                    tstc_pkg::FracW'($urandom_range(0, 17'h1ffff)));
          write_reg(tstc_pkg::CfgCountCutoff, tstc_pkg::FracW'($urandom_range(0, 3)));
        end
      endcase
      for (int k = 0; k < 14; k++)
        send_series(($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
                                                : $urandom_range(1, 16),
                    $urandom_range(0, 3));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  // long receiver stall early on, while series keep coming
  initial begin
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    rx_hold = 1;
    repeat (1500) @(posedge clk_i);
    rx_hold = 0;
  end

  initial begin
    summary_t got, want;
    int unsigned w;
    wait (rst_ni);
    forever begin
      w = $urandom_range(0, 4);
      if (w != 0 || rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      if (summary_q.size() == 0) begin
        $error("summary transfer with none expected: %h", got);
        errors++;
      end else begin
        want = summary_q.pop_front();
        if (got.min_value !== want.min_value)
          $error("min_value exp %h got %h", want.min_value, got.min_value);
        if (got.max_value !== want.max_value)
          $error("max_value exp %h got %h", want.max_value, got.max_value);
        if (got.min_position !== want.min_position)
          $error("min_position exp %0d got %0d", want.min_position, got.min_position);
        if (got.max_position !== want.max_position)
          $error("max_position exp %0d got %0d", want.max_position, got.max_position);
        if (got.start_end_diff !== want.start_end_diff)
          $error("start_end_diff exp %h got %h", want.start_end_diff, got.start_end_diff);
        if (got.spread !== want.spread)
          $error("spread exp %h got %h", want.spread, got.spread);
        if (got.max_step !== want.max_step)
          $error("max_step exp %h got %h", want.max_step, got.max_step);
        if (got.forward !== want.forward)
          $error("forward exp %b got %b", want.forward, got.forward);
        if (got.pattern_flags !== want.pattern_flags)
          $error("pattern_flags exp %b got %b", want.pattern_flags, got.pattern_flags);
        if (got.overflowed !== want.overflowed)
          $error("overflowed exp %b got %b", want.overflowed, got.overflowed);
        if (got.zfill !== want.zfill)
          $error("zfill exp %h got %h", want.zfill, got.zfill);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (2 * NPts + 20) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end
endmodule
